// ===== design/mlfb_pkg.sv =====
// shared types, constants and font table for the text and pixel draw engine
package mlfb_pkg;

  localparam int COLUMNS_DEF   = 84;
  localparam int BANKS_DEF     = 6;
  localparam int GLYPH_COLUMNS = 5;

  localparam logic [6:0] FONT_FIRST = 7'h20;
  localparam logic [7:0] CMD_BANK   = 8'h40;
  localparam logic [7:0] CMD_COLUMN = 8'h80;

  typedef enum logic [2:0] {
    CMD_MOVE, CMD_CHAR, CMD_SET, CMD_CLR_PIX, CMD_RECT, CMD_ERASE, CMD_CLEAR, CMD_READ
  } cmd_t;

  typedef enum logic [1:0] {KIND_CMD, KIND_DATA, KIND_READ, KIND_DONE} kind_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLR, ST_MV_MOD, ST_MV_BANK, ST_MV_COL, ST_CHAR, ST_RECT,
    ST_PIX_RD, ST_PIX_WR, ST_RD_REQ, ST_RD_OUT, ST_DONE
  } st_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [6:0] col_a;
    logic [5:0] row_a;
    logic [6:0] col_b;
    logic [5:0] row_b;
    logic [6:0] glyph_code;
    logic [8:0] read_index;
  } item_t;

  typedef struct packed {
    logic init_busy;
  } back_stat_t;

  // first glyph column in the highest byte
  localparam logic [39:0] FONT [96] = '{
    40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
    40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
    40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
    40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
    40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
    40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
    40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
    40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
    40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
    40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
    40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
    40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
    40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
    40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
    40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
    40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
    40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h7846414678
  };

  function automatic logic [7:0] font_byte(input logic [6:0] code, input logic [2:0] col);
    logic [6:0]  idx;
    logic [39:0] row;
    logic [7:0]  res;
    idx = code - FONT_FIRST;
    row = FONT[idx];
    res = 8'h00;
    case (col)
      3'd0: res = row[39:32];
      3'd1: res = row[31:24];
      3'd2: res = row[23:16];
      3'd3: res = row[15:8];
      3'd4: res = row[7:0];
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

// ===== design/mono_lcd_framebuffer_text_draw_core.sv =====
// top level: request queue in front of the frame store command executor
// the two-entry request queue takes requests while a command runs, but the
// executor starts the next command only once it is back in idle; results leave
// one per cycle while out_tready does not hold them; the store has a single
// write port and a registered read, and one result register drives the output
// reset: store cleared by a sweep over all COLUMNS*BANKS bytes, no request taken meanwhile
module mono_lcd_framebuffer_text_draw_core
  import mlfb_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int BANKS   = BANKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // cmd
  input  logic [47:0] in_tdata,   // col_a, row_a, col_b, row_b, glyph_code, read_index
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // kind
  output logic [7:0]  out_tdata,  // value
  output logic        out_tlast
);

  logic       q_valid, q_ready;
  item_t      q_item;
  back_stat_t stat;

  mlfb_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .stat(stat), .q_valid(q_valid), .q_item(q_item), .q_ready(q_ready)
  );

  mlfb_back #(.COLUMNS(COLUMNS), .BANKS(BANKS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_item(q_item), .q_ready(q_ready), .stat(stat),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

endmodule

// ===== design/mlfb_ram.sv =====
// generic single write port ram with registered read
module mlfb_ram #(
  parameter int W = 8,
  parameter int D = 504
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/mlfb_front.sv =====
// request intake: decodes the stream into commands and queues them
module mlfb_front
  import mlfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [2:0] in_tuser,
  input  logic [47:0] in_tdata,
  input  back_stat_t stat,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_ready
);

  item_t      mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  item_t      item;
  logic       push, pop;

  always_comb begin
    item.cmd        = cmd_t'(in_tuser);
    item.col_a      = in_tdata[6:0];
    item.row_a      = in_tdata[12:7];
    item.col_b      = in_tdata[19:13];
    item.row_b      = in_tdata[25:20];
    item.glyph_code = in_tdata[32:26];
    item.read_index = in_tdata[41:33];
  end

  assign in_tready = (cnt_r != 2'd2) && !stat.init_busy;
  assign push      = in_tvalid && in_tready;
  assign q_valid   = cnt_r != 2'd0;
  assign pop       = q_valid && q_ready;
  assign q_item    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= item;
    end
  end

endmodule

// ===== design/mlfb_back.sv =====
// command executor: frame store sequencer and result register
module mlfb_back
  import mlfb_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int BANKS   = BANKS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       q_ready,
  output back_stat_t stat,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [1:0] out_tuser,
  output logic [7:0] out_tdata,
  output logic       out_tlast
);

  localparam int STORE = COLUMNS * BANKS;
  localparam int AW    = $clog2(STORE);
  localparam int SW    = 13;

  st_t         st_r, st_nxt;
  item_t       it_r, it_nxt;
  logic [AW-1:0] cur_r, cur_nxt, clr_r, clr_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        init_r, init_nxt;
  logic [7:0]  ri_r, ri_nxt;
  logic        rsel_r, rsel_nxt, rph_r, rph_nxt;
  logic [7:0]  px_r, px_nxt;
  logic [5:0]  py_r, py_nxt;
  logic        ov_r, ov_nxt, olast_r, olast_nxt;
  kind_t       okind_r, okind_nxt;
  logic [7:0]  oval_r, oval_nxt;

  logic          we, re;
  logic [AW-1:0] waddr, raddr, pix_addr;
  logic [7:0]    wdata, rdata, pix_bit;
  logic          can_emit, pix_ok, is_rect, pix_on, rd_ok, clr_last;
  logic [5:0]    bank;
  logic [5:0]    q_bank;

  mlfb_ram #(.W(8), .D(STORE)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  assign can_emit = !ov_r || out_tready;
  assign q_ready  = st_r == ST_IDLE;
  assign stat.init_busy = init_r;
  assign is_rect  = (it_r.cmd == CMD_RECT) || (it_r.cmd == CMD_ERASE);
  assign pix_on   = (it_r.cmd == CMD_SET) || (it_r.cmd == CMD_RECT);
  assign pix_ok   = (32'(px_r) < COLUMNS) && (32'(py_r) < 8 * BANKS);
  assign pix_addr = AW'(32'(py_r[5:3]) * COLUMNS + 32'(px_r));
  assign pix_bit  = 8'b1 << py_r[2:0];
  assign rd_ok    = 32'(it_r.read_index) < STORE;
  assign clr_last = clr_r == AW'(STORE - 1);
  assign bank     = (32'(it_r.row_a) > BANKS - 1) ? 6'(BANKS - 1) : it_r.row_a;
  assign q_bank   = (32'(q_item.row_a) > BANKS - 1) ? 6'(BANKS - 1) : q_item.row_a;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_item.cmd)
            CMD_MOVE:  st_nxt = ST_MV_MOD;
            CMD_CHAR:  st_nxt = ST_CHAR;
            CMD_CLEAR: st_nxt = ST_CLR;
            CMD_READ:  st_nxt = ST_RD_REQ;
            default: begin
              if (q_item.cmd inside {CMD_RECT, CMD_ERASE}) st_nxt = ST_RECT;
              else st_nxt = ST_PIX_RD;
            end
          endcase
        end
      end
      ST_CLR:     if (clr_last) st_nxt = init_r ? ST_IDLE : ST_DONE;
      ST_MV_MOD:  if (32'(sum_r) < STORE) st_nxt = ST_MV_BANK;
      ST_MV_BANK: if (can_emit) st_nxt = ST_MV_COL;
      ST_MV_COL:  if (can_emit) st_nxt = ST_IDLE;
      ST_CHAR:    if (can_emit && cnt_r == 3'd5) st_nxt = ST_IDLE;
      ST_RECT: begin
        if (!rph_r) begin
          if (ri_r <= {1'b0, it_r.col_b}) st_nxt = ST_PIX_RD;
        end else begin
          st_nxt = (ri_r <= {2'b0, it_r.row_b}) ? ST_PIX_RD : ST_DONE;
        end
      end
      ST_PIX_RD:  st_nxt = pix_ok ? ST_PIX_WR : (is_rect ? ST_RECT : ST_DONE);
      ST_PIX_WR:  st_nxt = is_rect ? ST_RECT : ST_DONE;
      ST_RD_REQ:  st_nxt = ST_RD_OUT;
      ST_RD_OUT:  if (can_emit) st_nxt = ST_IDLE;
      ST_DONE:    if (can_emit) st_nxt = ST_IDLE;
      default:    st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    it_nxt    = it_r;
    cur_nxt   = cur_r;
    clr_nxt   = clr_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    init_nxt  = init_r;
    ri_nxt    = ri_r;
    rsel_nxt  = rsel_r;
    rph_nxt   = rph_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    ov_nxt    = ov_r && !out_tready;
    okind_nxt = okind_r;
    oval_nxt  = oval_r;
    olast_nxt = olast_r;
    we        = 1'b0;
    re        = 1'b0;
    waddr     = pix_addr;
    raddr     = pix_addr;
    wdata     = 8'h00;
    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          it_nxt   = q_item;
          sum_nxt  = SW'(32'(q_item.col_a) + 32'(q_bank) * COLUMNS);
          cnt_nxt  = 3'd0;
          clr_nxt  = '0;
          rph_nxt  = 1'b0;
          rsel_nxt = 1'b0;
          ri_nxt   = {1'b0, q_item.col_a};
          px_nxt   = {1'b0, q_item.col_a};
          py_nxt   = q_item.row_a;
        end
      end
      ST_CLR: begin
        we      = 1'b1;
        waddr   = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_last) init_nxt = 1'b0;
      end
      ST_MV_MOD: begin
        if (32'(sum_r) >= STORE) sum_nxt = sum_r - SW'(STORE);
        else cur_nxt = AW'(sum_r);
      end
      ST_MV_BANK: begin
        if (can_emit) begin
          ov_nxt = 1'b1; okind_nxt = KIND_CMD;
          oval_nxt = CMD_BANK | {2'b0, bank}; olast_nxt = 1'b0;
        end
      end
      ST_MV_COL: begin
        if (can_emit) begin
          ov_nxt = 1'b1; okind_nxt = KIND_CMD;
          oval_nxt = CMD_COLUMN | {1'b0, it_r.col_a}; olast_nxt = 1'b1;
        end
      end
      ST_CHAR: begin
        if (can_emit) begin
          wdata = ((cnt_r < 3'(GLYPH_COLUMNS)) && (it_r.glyph_code >= FONT_FIRST)) ?
                  font_byte(it_r.glyph_code, cnt_r) : 8'h00;
          we = 1'b1; waddr = cur_r;
          cur_nxt = (cur_r == AW'(STORE - 1)) ? '0 : cur_r + AW'(1);
          cnt_nxt = cnt_r + 3'd1;
          ov_nxt = 1'b1; okind_nxt = KIND_DATA; oval_nxt = wdata;
          olast_nxt = cnt_r == 3'd5;
        end
      end
      ST_RECT: begin
        if (!rph_r) begin
          if (ri_r <= {1'b0, it_r.col_b}) begin
            px_nxt = ri_r;
            py_nxt = rsel_r ? it_r.row_b : it_r.row_a;
            rsel_nxt = !rsel_r;
            if (rsel_r) ri_nxt = ri_r + 8'd1;
          end else begin
            rph_nxt = 1'b1; rsel_nxt = 1'b0; ri_nxt = {2'b0, it_r.row_a};
          end
        end else begin
          if (ri_r <= {2'b0, it_r.row_b}) begin
            px_nxt = {1'b0, rsel_r ? it_r.col_b : it_r.col_a};
            py_nxt = ri_r[5:0];
            rsel_nxt = !rsel_r;
            if (rsel_r) ri_nxt = ri_r + 8'd1;
          end
        end
      end
      ST_PIX_RD: re = pix_ok;
      ST_PIX_WR: begin
        we = 1'b1;
        wdata = pix_on ? (rdata | pix_bit) : (rdata & ~pix_bit);
      end
      ST_RD_REQ: begin
        re = rd_ok;
        raddr = AW'(it_r.read_index);
      end
      ST_RD_OUT: begin
        if (can_emit) begin
          ov_nxt = 1'b1; okind_nxt = KIND_READ;
          oval_nxt = rd_ok ? rdata : 8'h00; olast_nxt = 1'b1;
        end
      end
      ST_DONE: begin
        if (can_emit) begin
          ov_nxt = 1'b1; okind_nxt = KIND_DONE; oval_nxt = 8'h00; olast_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_CLR;
      init_r <= 1'b1;
      clr_r  <= '0;
      cur_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      init_r <= init_nxt;
      clr_r  <= clr_nxt;
      cur_r  <= cur_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    it_r    <= it_nxt;
    sum_r   <= sum_nxt;
    cnt_r   <= cnt_nxt;
    ri_r    <= ri_nxt;
    rsel_r  <= rsel_nxt;
    rph_r   <= rph_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    okind_r <= okind_nxt;
    oval_r  <= oval_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = okind_r;
  assign out_tdata  = oval_r;
  assign out_tlast  = olast_r;

endmodule

// ===== tb/sv/tb_mono_lcd_framebuffer_text_draw_core.sv =====
// testbench for the text and pixel draw engine: predicted results checked in order
module tb_mono_lcd_framebuffer_text_draw_core;
  import mlfb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCOL = COLUMNS_DEF;
  localparam int NBANK = BANKS_DEF;
  localparam int NBYTES = NCOL * NBANK;
  localparam int NROWS = NBANK * 8;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic       last;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [2:0]  in_tuser = '0;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [1:0]  out_tuser;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  logic [7:0]  pic [NBYTES];
  int          cursor;
  reply_t      pending [$];
  int          errors = 0;
  int          stall_left = 0;

  mono_lcd_framebuffer_text_draw_core dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] glyph_col(logic [6:0] code, int c);
    logic [7:0] g [96][5] = '{
      '{8'h00,8'h00,8'h00,8'h00,8'h00},'{8'h00,8'h00,8'h5f,8'h00,8'h00},
      '{8'h00,8'h07,8'h00,8'h07,8'h00},'{8'h14,8'h7f,8'h14,8'h7f,8'h14},
      '{8'h24,8'h2a,8'h7f,8'h2a,8'h12},'{8'h23,8'h13,8'h08,8'h64,8'h62},
      '{8'h36,8'h49,8'h55,8'h22,8'h50},'{8'h00,8'h05,8'h03,8'h00,8'h00},
      '{8'h00,8'h1c,8'h22,8'h41,8'h00},'{8'h00,8'h41,8'h22,8'h1c,8'h00},
      '{8'h14,8'h08,8'h3e,8'h08,8'h14},'{8'h08,8'h08,8'h3e,8'h08,8'h08},
      '{8'h00,8'h50,8'h30,8'h00,8'h00},'{8'h08,8'h08,8'h08,8'h08,8'h08},
      '{8'h00,8'h60,8'h60,8'h00,8'h00},'{8'h20,8'h10,8'h08,8'h04,8'h02},
      '{8'h3e,8'h51,8'h49,8'h45,8'h3e},'{8'h00,8'h42,8'h7f,8'h40,8'h00},
      '{8'h42,8'h61,8'h51,8'h49,8'h46},'{8'h21,8'h41,8'h45,8'h4b,8'h31},
      '{8'h18,8'h14,8'h12,8'h7f,8'h10},'{8'h27,8'h45,8'h45,8'h45,8'h39},
      '{8'h3c,8'h4a,8'h49,8'h49,8'h30},'{8'h01,8'h71,8'h09,8'h05,8'h03},
      '{8'h36,8'h49,8'h49,8'h49,8'h36},'{8'h06,8'h49,8'h49,8'h29,8'h1e},
      '{8'h00,8'h36,8'h36,8'h00,8'h00},'{8'h00,8'h56,8'h36,8'h00,8'h00},
      '{8'h08,8'h14,8'h22,8'h41,8'h00},'{8'h14,8'h14,8'h14,8'h14,8'h14},
      '{8'h00,8'h41,8'h22,8'h14,8'h08},'{8'h02,8'h01,8'h51,8'h09,8'h06},
      '{8'h32,8'h49,8'h79,8'h41,8'h3e},'{8'h7e,8'h11,8'h11,8'h11,8'h7e},
      '{8'h7f,8'h49,8'h49,8'h49,8'h36},'{8'h3e,8'h41,8'h41,8'h41,8'h22},
      '{8'h7f,8'h41,8'h41,8'h22,8'h1c},'{8'h7f,8'h49,8'h49,8'h49,8'h41},
      '{8'h7f,8'h09,8'h09,8'h09,8'h01},'{8'h3e,8'h41,8'h49,8'h49,8'h7a},
      '{8'h7f,8'h08,8'h08,8'h08,8'h7f},'{8'h00,8'h41,8'h7f,8'h41,8'h00},
      '{8'h20,8'h40,8'h41,8'h3f,8'h01},'{8'h7f,8'h08,8'h14,8'h22,8'h41},
      '{8'h7f,8'h40,8'h40,8'h40,8'h40},'{8'h7f,8'h02,8'h0c,8'h02,8'h7f},
      '{8'h7f,8'h04,8'h08,8'h10,8'h7f},'{8'h3e,8'h41,8'h41,8'h41,8'h3e},
      '{8'h7f,8'h09,8'h09,8'h09,8'h06},'{8'h3e,8'h41,8'h51,8'h21,8'h5e},
      '{8'h7f,8'h09,8'h19,8'h29,8'h46},'{8'h46,8'h49,8'h49,8'h49,8'h31},
      '{8'h01,8'h01,8'h7f,8'h01,8'h01},'{8'h3f,8'h40,8'h40,8'h40,8'h3f},
      '{8'h1f,8'h20,8'h40,8'h20,8'h1f},'{8'h3f,8'h40,8'h38,8'h40,8'h3f},
      '{8'h63,8'h14,8'h08,8'h14,8'h63},'{8'h07,8'h08,8'h70,8'h08,8'h07},
      '{8'h61,8'h51,8'h49,8'h45,8'h43},'{8'h00,8'h7f,8'h41,8'h41,8'h00},
      '{8'h02,8'h04,8'h08,8'h10,8'h20},'{8'h00,8'h41,8'h41,8'h7f,8'h00},
      '{8'h04,8'h02,8'h01,8'h02,8'h04},'{8'h40,8'h40,8'h40,8'h40,8'h40},
      '{8'h00,8'h01,8'h02,8'h04,8'h00},'{8'h20,8'h54,8'h54,8'h54,8'h78},
      '{8'h7f,8'h48,8'h44,8'h44,8'h38},'{8'h38,8'h44,8'h44,8'h44,8'h20},
      '{8'h38,8'h44,8'h44,8'h48,8'h7f},'{8'h38,8'h54,8'h54,8'h54,8'h18},
      '{8'h08,8'h7e,8'h09,8'h01,8'h02},'{8'h0c,8'h52,8'h52,8'h52,8'h3e},
      '{8'h7f,8'h08,8'h04,8'h04,8'h78},'{8'h00,8'h44,8'h7d,8'h40,8'h00},
      '{8'h20,8'h40,8'h44,8'h3d,8'h00},'{8'h7f,8'h10,8'h28,8'h44,8'h00},
      '{8'h00,8'h41,8'h7f,8'h40,8'h00},'{8'h7c,8'h04,8'h18,8'h04,8'h78},
      '{8'h7c,8'h08,8'h04,8'h04,8'h78},'{8'h38,8'h44,8'h44,8'h44,8'h38},
      '{8'h7c,8'h14,8'h14,8'h14,8'h08},'{8'h08,8'h14,8'h14,8'h18,8'h7c},
      '{8'h7c,8'h08,8'h04,8'h04,8'h08},'{8'h48,8'h54,8'h54,8'h54,8'h20},
      '{8'h04,8'h3f,8'h44,8'h40,8'h20},'{8'h3c,8'h40,8'h40,8'h20,8'h7c},
      '{8'h1c,8'h20,8'h40,8'h20,8'h1c},'{8'h3c,8'h40,8'h30,8'h40,8'h3c},
      '{8'h44,8'h28,8'h10,8'h28,8'h44},'{8'h0c,8'h50,8'h50,8'h50,8'h3c},
      '{8'h44,8'h64,8'h54,8'h4c,8'h44},'{8'h00,8'h08,8'h36,8'h41,8'h00},
      '{8'h00,8'h00,8'h7f,8'h00,8'h00},'{8'h00,8'h41,8'h36,8'h08,8'h00},
      '{8'h10,8'h08,8'h08,8'h10,8'h08},'{8'h78,8'h46,8'h41,8'h46,8'h78}};
    if (code < FONT_FIRST) return 8'h00;
    return g[code - FONT_FIRST][c];
  endfunction

  task automatic plot(int c, int r, bit on);
    int idx;
    if (c >= NCOL || r >= NROWS) return;
    idx = (r / 8) * NCOL + c;
    pic[idx][r % 8] = on;
  endtask

  task automatic push_reply(kind_t k, logic [7:0] v, logic l);
    reply_t e;
    e.kind = k;
    e.value = v;
    e.last = l;
    pending.push_back(e);
  endtask

  task automatic predict_draw(item_t it);
    int bank;
    logic [7:0] v;
    case (it.cmd)
      CMD_MOVE: begin
        bank = (int'(it.row_a) > NBANK - 1) ? NBANK - 1 : int'(it.row_a);
        cursor = (int'(it.col_a) + bank * NCOL) % NBYTES;
        push_reply(KIND_CMD, CMD_BANK | 8'(bank), 1'b0);
        push_reply(KIND_CMD, CMD_COLUMN | {1'b0, it.col_a}, 1'b1);
      end
      CMD_CHAR: begin
        for (int i = 0; i <= GLYPH_COLUMNS; i++) begin
          v = (i < GLYPH_COLUMNS) ? glyph_col(it.glyph_code, i) : 8'h00;
          pic[cursor] = v;
          cursor = (cursor + 1) % NBYTES;
          push_reply(KIND_DATA, v, i == GLYPH_COLUMNS);
        end
      end
      CMD_SET, CMD_CLR_PIX: begin
        plot(int'(it.col_a), int'(it.row_a), it.cmd == CMD_SET);
        push_reply(KIND_DONE, 8'h00, 1'b1);
      end
      CMD_RECT, CMD_ERASE: begin
        for (int i = int'(it.col_a); i <= int'(it.col_b); i++) begin
          plot(i, int'(it.row_a), it.cmd == CMD_RECT);
          plot(i, int'(it.row_b), it.cmd == CMD_RECT);
        end
        for (int i = int'(it.row_a); i <= int'(it.row_b); i++) begin
          plot(int'(it.col_a), i, it.cmd == CMD_RECT);
          plot(int'(it.col_b), i, it.cmd == CMD_RECT);
        end
        push_reply(KIND_DONE, 8'h00, 1'b1);
      end
      CMD_CLEAR: begin
        foreach (pic[i]) pic[i] = 8'h00;
        push_reply(KIND_DONE, 8'h00, 1'b1);
      end
      default: push_reply(KIND_READ, (it.read_index < NBYTES) ? pic[it.read_index] : 8'h00, 1'b1);
    endcase
  endtask

  task automatic send_request(item_t it);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.cmd;
    in_tdata <= {6'b0, it.read_index, it.glyph_code, it.row_b, it.col_b, it.row_a, it.col_a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_draw(it);
    @(negedge clk);
  endtask

  task automatic send_fields(cmd_t c, int ca, int ra, int cb, int rb, int gc, int ri);
    item_t it;
    it.cmd = c;
    it.col_a = 7'(ca);
    it.row_a = 6'(ra);
    it.col_b = 7'(cb);
    it.row_b = 6'(rb);
    it.glyph_code = 7'(gc);
    it.read_index = 9'(ri);
    send_request(it);
  endtask

  function automatic item_t rand_item(bit wild);
    item_t it;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    it.cmd = cmd_t'(3'($urandom_range(0, 7)));
    if (!wild) begin
      it.col_a = 7'($urandom_range(0, NCOL - 1));
      it.row_a = 6'($urandom_range(0, NROWS - 1));
      it.col_b = 7'($urandom_range(int'(it.col_a), NCOL - 1));
      it.row_b = 6'($urandom_range(int'(it.row_a), NROWS - 1));
      if ($urandom_range(0, 3) == 0) it.read_index = 9'($urandom_range(0, NBYTES - 1));
    end
    if (it.cmd == CMD_CLEAR && $urandom_range(0, 3) != 0) it.cmd = CMD_READ;
    return it;
  endfunction

  always @(posedge clk) begin
    reply_t e;
    if (out_tvalid && out_tready) begin
      if (pending.size() == 0) begin
        $error("unexpected result kind %0d value %0h", out_tuser, out_tdata);
        errors++;
      end else begin
        e = pending.pop_front();
        if (out_tuser !== e.kind) begin
          $error("kind expected %0d actual %0d", e.kind, out_tuser);
          errors++;
        end
        if (out_tdata !== e.value) begin
          $error("value expected %0h actual %0h", e.value, out_tdata);
          errors++;
        end
        if (out_tlast !== e.last) begin
          $error("last expected %0b actual %0b", e.last, out_tlast);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      stall_left = gap_len();
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic test_directed();
    send_fields(CMD_READ, 0, 0, 0, 0, 0, 0);
    send_fields(CMD_READ, 0, 0, 0, 0, 0, 511);
    send_fields(CMD_MOVE, 83, 5, 0, 0, 0, 0);
    send_fields(CMD_CHAR, 0, 0, 0, 0, 7'h41, 0);
    send_fields(CMD_READ, 0, 0, 0, 0, 0, 503);
    send_fields(CMD_READ, 0, 0, 0, 0, 0, 0);
    send_fields(CMD_MOVE, 127, 63, 0, 0, 0, 0);
    send_fields(CMD_CHAR, 0, 0, 0, 0, 7'h05, 0);
    send_fields(CMD_CHAR, 0, 0, 0, 0, 7'h7f, 0);
    send_fields(CMD_CHAR, 0, 0, 0, 0, 7'h20, 0);
    send_fields(CMD_SET, 0, 0, 0, 0, 0, 0);
    send_fields(CMD_SET, 83, 47, 0, 0, 0, 0);
    send_fields(CMD_SET, 84, 48, 0, 0, 0, 0);
    send_fields(CMD_SET, 127, 63, 0, 0, 0, 0);
    send_fields(CMD_CLR_PIX, 0, 0, 0, 0, 0, 0);
    send_fields(CMD_RECT, 0, 0, 83, 47, 0, 0);
    send_fields(CMD_RECT, 80, 40, 127, 63, 0, 0);
    send_fields(CMD_RECT, 50, 10, 20, 30, 0, 0);
    send_fields(CMD_ERASE, 10, 30, 40, 5, 0, 0);
    send_fields(CMD_READ, 0, 0, 0, 0, 0, 83);
    send_fields(CMD_READ, 0, 0, 0, 0, 0, 420);
    send_fields(CMD_ERASE, 0, 0, 83, 47, 0, 0);
    send_fields(CMD_READ, 0, 0, 0, 0, 0, 1);
    send_fields(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
    send_fields(CMD_READ, 0, 0, 0, 0, 0, 84);
  endtask

  task automatic test_random();
    item_t it;
    for (int n = 0; n < 450; n++) begin
      if ($urandom_range(0, 4) == 0) begin
        send_fields(CMD_MOVE, $urandom_range(0, 127), $urandom_range(0, 63), 0, 0, 0, 0);
        n++;
        repeat ($urandom_range(1, 4)) begin
          send_fields(CMD_CHAR, 0, 0, 0, 0, $urandom_range(0, 127), 0);
          n++;
        end
      end
      it = rand_item($urandom_range(0, 3) == 0);
      send_request(it);
    end
  endtask

  initial begin
    foreach (pic[i]) pic[i] = 8'h00;
    cursor = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random();
    in_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
